// ===== rtl/buffer_queue_manager_defines.svh =====
// Assertion macros used by the buffer queue manager controller (bqm_ctrl).
// No dependencies.
`ifndef BUFFER_QUEUE_MANAGER_DEFINES_SVH
`define BUFFER_QUEUE_MANAGER_DEFINES_SVH

// implication checked every clock unless in reset
`define BQM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqm check failed");

// next-cycle implication
`define BQM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqm check failed");

`endif

// ===== rtl/bqm_pkg.sv =====
// Package for the buffer queue manager: types, request and status codes.
// No dependencies.
`default_nettype none
package bqm_pkg;
    localparam int NUM_SLOTS_DEF = 64;
    localparam int CNT_W = 7;
    localparam int SLOT_W = 6;

    typedef enum logic [1:0] {
        REQ_GET  = 2'd0,
        REQ_FREE = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_NOP  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MEM_LIMIT = 3'd1,
        ST_POOL_EMPTY = 3'd2,
        ST_QUEUE_EMPTY = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_INIT_POOL,
        OP_GET_RD,
        OP_GET_WR,
        OP_FREE_RD,
        OP_FREE_STEP,
        OP_DEL_CACHE_RD,
        OP_DEL_CACHE_WR,
        OP_DEL_USED_RD,
        OP_DEL_USED_WR,
        OP_DONE
    } op_t;

    typedef struct packed {
        logic init_done;
        logic cache_nz;
        logic over_budget;
        logic pool_empty;
        logic used_empty;
        logic used_one;
        logic head_match;
        req_t req;
    } dp_status_t;
endpackage
`default_nettype wire

// ===== rtl/bqm_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module bqm_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bqm_datapath.sv =====
// Datapath: used ring, cache stack and pool stack memories with counters.
// Depends on bqm_pkg and bqm_ram.
`default_nettype none
module bqm_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bqm_pkg::op_t               op,
    input  wire logic [1:0]                 req_type,
    input  wire logic [bqm_pkg::SLOT_W-1:0] limit_slot,
    input  wire logic [bqm_pkg::CNT_W-1:0]  cache_cap,
    input  wire logic [bqm_pkg::CNT_W-1:0]  mem_limit,
    output bqm_pkg::dp_status_t             stat,
    output logic [2:0]                      status,
    output logic [bqm_pkg::SLOT_W-1:0]      buf_slot,
    output logic [bqm_pkg::CNT_W-1:0]       buffers_held,
    output logic [bqm_pkg::CNT_W-1:0]       released_count
);
    localparam int NUM_SLOTS = bqm_pkg::NUM_SLOTS_DEF;
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int SW = bqm_pkg::SLOT_W;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] used_cnt_reg, used_cnt_next;
    logic [CW-1:0] cache_cnt_reg, cache_cnt_next;
    logic [CW-1:0] pool_cnt_reg, pool_cnt_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] init_reg, init_next;
    logic [CW-1:0] rel_reg, rel_next;
    logic [SW-1:0] lim_reg, lim_next;
    bqm_pkg::req_t req_reg, req_next;
    logic [2:0]    st_reg, st_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          from_pool_reg, from_pool_next;

    logic          u_we, c_we, p_we;
    logic [AW-1:0] u_wa, c_wa, p_wa, u_ra, c_ra, p_ra;
    logic [SW-1:0] u_wd, c_wd, p_wd, u_rd, c_rd, p_rd;
    logic [CW:0]   cap_eff;
    logic [CW:0]   mem_lim_w;

    bqm_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_used (
        .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));
    bqm_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_cache (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
    bqm_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_pool (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    always_comb
    begin
        mem_lim_w = (CW+1)'(mem_limit);
        if ((CW+1)'(cache_cap) > (CW+1)'(NUM_SLOTS))
            cap_eff = (CW+1)'(NUM_SLOTS);
        else
            cap_eff = (CW+1)'(cache_cap);
    end

    assign u_ra = AW'(head_reg);
    assign c_ra = AW'(cache_cnt_reg - CW'(1));
    assign p_ra = AW'(pool_cnt_reg - CW'(1));

    always_comb
    begin
        stat.init_done   = (init_reg == CW'(NUM_SLOTS));
        stat.cache_nz    = (cache_cnt_reg != '0);
        stat.over_budget = ((CW+1)'(held_reg) >= mem_lim_w);
        stat.pool_empty  = (pool_cnt_reg == '0);
        stat.used_empty  = (used_cnt_reg == '0);
        stat.used_one    = (used_cnt_reg == CW'(1));
        stat.head_match  = (u_rd == lim_reg);
        stat.req         = req_reg;
    end

    always_comb
    begin
        head_next      = head_reg;
        used_cnt_next  = used_cnt_reg;
        cache_cnt_next = cache_cnt_reg;
        pool_cnt_next  = pool_cnt_reg;
        held_next      = held_reg;
        init_next      = init_reg;
        rel_next       = rel_reg;
        lim_next       = lim_reg;
        req_next       = req_reg;
        st_next        = st_reg;
        slot_next      = slot_reg;
        from_pool_next = from_pool_reg;
        u_we = 1'b0; c_we = 1'b0; p_we = 1'b0;
        u_wa = AW'(head_reg + AW'(used_cnt_reg));
        u_wd = slot_reg;
        c_wa = AW'(cache_cnt_reg);
        c_wd = u_rd;
        p_wa = AW'(pool_cnt_reg);
        p_wd = u_rd;
        unique case (op)
            bqm_pkg::OP_INIT_POOL:
            begin
                p_we = 1'b1;
                p_wa = AW'(init_reg);
                p_wd = SW'(CW'(NUM_SLOTS - 1) - init_reg);
                init_next = init_reg + CW'(1);
            end
            bqm_pkg::OP_LATCH:
            begin
                req_next  = bqm_pkg::req_t'(req_type);
                lim_next  = limit_slot;
                rel_next  = '0;
                st_next   = bqm_pkg::ST_OK;
                slot_next = '0;
            end
            bqm_pkg::OP_GET_RD:
            begin
                if (cache_cnt_reg != '0)
                begin
                    cache_cnt_next = cache_cnt_reg - CW'(1);
                    from_pool_next = 1'b0;
                end
                else if ((CW+1)'(held_reg) >= mem_lim_w)
                    st_next = bqm_pkg::ST_MEM_LIMIT;
                else if (pool_cnt_reg == '0)
                    st_next = bqm_pkg::ST_POOL_EMPTY;
                else
                begin
                    pool_cnt_next  = pool_cnt_reg - CW'(1);
                    held_next      = held_reg + CW'(1);
                    from_pool_next = 1'b1;
                end
            end
            bqm_pkg::OP_GET_WR:
            begin
                slot_next = from_pool_reg ? p_rd : c_rd;
                u_wd      = slot_next;
                if (used_cnt_reg < CW'(NUM_SLOTS))
                begin
                    u_we = 1'b1;
                    used_cnt_next = used_cnt_reg + CW'(1);
                end
            end
            bqm_pkg::OP_FREE_STEP:
            begin
                if ((CW+1)'(cache_cnt_reg) < cap_eff)
                begin
                    c_we = 1'b1;
                    cache_cnt_next = cache_cnt_reg + CW'(1);
                end
                else
                begin
                    if (pool_cnt_reg < CW'(NUM_SLOTS))
                    begin
                        p_we = 1'b1;
                        pool_cnt_next = pool_cnt_reg + CW'(1);
                    end
                    if (held_reg != '0)
                        held_next = held_reg - CW'(1);
                end
                head_next     = AW'(head_reg + AW'(1));
                used_cnt_next = used_cnt_reg - CW'(1);
                rel_next      = rel_reg + CW'(1);
            end
            bqm_pkg::OP_DEL_CACHE_RD:
                cache_cnt_next = cache_cnt_reg - CW'(1);
            bqm_pkg::OP_DEL_CACHE_WR:
            begin
                p_wd = c_rd;
                if (pool_cnt_reg < CW'(NUM_SLOTS))
                begin
                    p_we = 1'b1;
                    pool_cnt_next = pool_cnt_reg + CW'(1);
                end
            end
            bqm_pkg::OP_DEL_USED_WR:
            begin
                if (pool_cnt_reg < CW'(NUM_SLOTS))
                begin
                    p_we = 1'b1;
                    pool_cnt_next = pool_cnt_reg + CW'(1);
                end
                head_next     = AW'(head_reg + AW'(1));
                used_cnt_next = used_cnt_reg - CW'(1);
                rel_next      = rel_reg + CW'(1);
            end
            bqm_pkg::OP_DONE:
            begin
                if (req_reg == bqm_pkg::REQ_DEL)
                    held_next = '0;
            end
            default:
            begin
            end
        endcase
        if (op == bqm_pkg::OP_FREE_RD && req_reg == bqm_pkg::REQ_FREE)
        begin
            if (used_cnt_reg == '0)
                st_next = bqm_pkg::ST_QUEUE_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            used_cnt_reg  <= '0;
            cache_cnt_reg <= '0;
            pool_cnt_reg  <= CW'(NUM_SLOTS);
            held_reg      <= '0;
            init_reg      <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            used_cnt_reg  <= used_cnt_next;
            cache_cnt_reg <= cache_cnt_next;
            pool_cnt_reg  <= pool_cnt_next;
            held_reg      <= held_next;
            init_reg      <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg       <= rel_next;
        lim_reg       <= lim_next;
        req_reg       <= req_next;
        st_reg        <= st_next;
        slot_reg      <= slot_next;
        from_pool_reg <= from_pool_next;
    end

    // limit-not-found decided in the done cycle from the remaining head entry
    always_comb
    begin
        status         = st_reg;
        buf_slot       = slot_reg;
        buffers_held   = bqm_pkg::CNT_W'(held_next);
        released_count = bqm_pkg::CNT_W'(rel_reg);
        if (op == bqm_pkg::OP_DONE && req_reg == bqm_pkg::REQ_FREE && st_reg == bqm_pkg::ST_OK
            && !stat.used_empty && !stat.head_match)
            status = bqm_pkg::ST_NOT_FOUND;
    end
endmodule
`default_nettype wire

// ===== rtl/bqm_ctrl.sv =====
// Controller state machine sequencing requests over the datapath.
// Depends on bqm_pkg and buffer_queue_manager_defines.svh.
`default_nettype none
`include "buffer_queue_manager_defines.svh"
module bqm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire bqm_pkg::dp_status_t stat,
    output bqm_pkg::op_t             op,
    output logic                     busy,
    output logic                     done
);
    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DISP  = 9'b000000100,
        S_GETW  = 9'b000001000,
        S_FRD   = 9'b000010000,
        S_FCHK  = 9'b000100000,
        S_CRD   = 9'b001000000,
        S_URD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   cwr_reg, cwr_next;
    logic   uwr_reg, uwr_next;

    always_comb
    begin
        state_next = state_reg;
        cwr_next   = 1'b0;
        uwr_next   = 1'b0;
        op         = bqm_pkg::OP_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                op = bqm_pkg::OP_INIT_POOL;
                if (stat.init_done)
                begin
                    op = bqm_pkg::OP_NONE;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op = bqm_pkg::OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.req)
                    bqm_pkg::REQ_GET:
                    begin
                        op = bqm_pkg::OP_GET_RD;
                        state_next = (stat.cache_nz || (!stat.over_budget && !stat.pool_empty))
                                     ? S_GETW : S_DONE;
                    end
                    bqm_pkg::REQ_FREE:
                    begin
                        op = bqm_pkg::OP_FREE_RD;
                        state_next = stat.used_empty ? S_DONE : S_FRD;
                    end
                    bqm_pkg::REQ_DEL:  state_next = S_CRD;
                    default:           state_next = S_DONE;
                endcase
            end
            S_GETW:
            begin
                op = bqm_pkg::OP_GET_WR;
                state_next = S_DONE;
            end
            S_FRD:
                state_next = S_FCHK;
            S_FCHK:
            begin
                if (stat.head_match || stat.used_one)
                    state_next = S_DONE;
                else
                begin
                    op = bqm_pkg::OP_FREE_STEP;
                    state_next = S_FRD;
                end
            end
            S_CRD:
            begin
                if (cwr_reg)
                begin
                    op = bqm_pkg::OP_DEL_CACHE_WR;
                end
                else if (stat.cache_nz)
                begin
                    op = bqm_pkg::OP_DEL_CACHE_RD;
                    cwr_next = 1'b1;
                end
                else
                    state_next = S_URD;
            end
            S_URD:
            begin
                if (uwr_reg)
                    op = bqm_pkg::OP_DEL_USED_WR;
                else if (!stat.used_empty)
                    uwr_next = 1'b1;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                op = bqm_pkg::OP_DONE;
                state_next = S_IDLE;
            end
            default:
                state_next = S_INIT;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cwr_reg   <= 1'b0;
            uwr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cwr_reg   <= cwr_next;
            uwr_reg   <= uwr_next;
        end
    end

    `BQM_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `BQM_ASSERT_NXT(a_done_idle, clk, rst_n, done, !busy)
    `BQM_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule
`default_nettype wire

// ===== rtl/buffer_queue_manager.sv =====
// Buffer queue manager top level: APB config registers, controller, datapath.
// Depends on bqm_pkg, bqm_ctrl, bqm_datapath. One request at a time.
// A free steps once per released buffer and a delete once per cached or queued
// buffer. done is high in S_DONE, just before the return to idle. After reset
// busy stays high while the pool is filled.
`default_nettype none
module buffer_queue_manager (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic [5:0]  limit_slot,
    output logic             done,
    output logic [2:0]       status,
    output logic [5:0]       buf_slot,
    output logic [6:0]       buffers_held,
    output logic [6:0]       released_count
);
    logic [6:0] cap_reg, lim_reg;
    bqm_pkg::op_t        op;
    bqm_pkg::dp_status_t stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {25'd0, lim_reg} : {25'd0, cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 7'd4;
            lim_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                lim_reg <= pwdata[6:0];
            else
                cap_reg <= pwdata[6:0];
        end
    end

    bqm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .op(op), .busy(busy), .done(done));

    bqm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .op(op), .req_type(req_type),
        .limit_slot(limit_slot), .cache_cap(cap_reg), .mem_limit(lim_reg),
        .stat(stat), .status(status), .buf_slot(buf_slot),
        .buffers_held(buffers_held), .released_count(released_count));
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for buffer_queue_manager: directed and random get/free/delete/nop requests,
// an in-line predictor of the queue, cache and pool, and APB register writes.
// Depends on bqm_pkg and the buffer_queue_manager RTL.
`timescale 1ns / 100ps
module tb_top;
    typedef struct {
        bqm_pkg::req_t req;
        int            lim_mode;   // 0 random, 1 slot in queue, 2 slot not in queue
    } request_t;

    typedef struct packed {
        logic [2:0] st;
        logic [5:0] slot;
        logic [6:0] held;
        logic [6:0] rel;
    } word_t;

    localparam int MODE_ANY = 0;
    localparam int MODE_IN = 1;
    localparam int MODE_OUT = 2;
    localparam logic ADDR_CACHE_CAP = 1'b0;
    localparam logic ADDR_MEM_LIMIT = 1'b1;
    localparam int MAX_CYCLES = 1000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [5:0]  limit_slot;
    logic        done;
    logic [2:0]  status;
    logic [5:0]  buf_slot;
    logic [6:0]  buffers_held;
    logic [6:0]  released_count;

    buffer_queue_manager dut (.*);

    // predicted block state
    logic [5:0] used_ring [64];
    logic [5:0] cache_stk [64];
    logic [5:0] pool_stk [64];
    int         q_first;
    int         used_cnt;
    int         cache_cnt;
    int         pool_cnt;
    int         held_cnt;
    int         cache_cap;
    int         mem_limit;

    request_t pending_reqs [$];
    word_t    expected_words [$];
    int       idle_pct;
    int       errors;
    int       checked;
    int       cycles;
    int       status_seen [5];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit slot_queued(logic [5:0] s);
        for (int i = 0; i < used_cnt; i++)
        begin
            if (used_ring[(q_first + i) % 64] == s)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [5:0] pick_limit(int mode);
        logic [5:0] s;
        s = 6'($urandom_range(63));
        if (mode == MODE_IN && used_cnt > 0)
            s = used_ring[(q_first + $urandom_range(used_cnt - 1)) % 64];
        else if (mode == MODE_OUT && used_cnt < 64)
        begin
            while (slot_queued(s))
                s = 6'($urandom_range(63));
        end
        return s;
    endfunction

    function automatic void pool_push(logic [5:0] s);
        if (pool_cnt < 64)
        begin
            pool_stk[pool_cnt] = s;
            pool_cnt++;
        end
    endfunction

    function automatic word_t apply_request(bqm_pkg::req_t rq, logic [5:0] lim);
        word_t    w;
        logic [5:0] s;
        bit       got;
        int       cap;
        w = '0;
        got = 1'b0;
        cap = (cache_cap > 64) ? 64 : cache_cap;
        case (rq)
            bqm_pkg::REQ_GET:
            begin
                if (cache_cnt > 0)
                begin
                    cache_cnt--;
                    s = cache_stk[cache_cnt];
                    got = 1'b1;
                end
                else if (held_cnt >= mem_limit)
                    w.st = bqm_pkg::ST_MEM_LIMIT;
                else if (pool_cnt == 0)
                    w.st = bqm_pkg::ST_POOL_EMPTY;
                else
                begin
                    pool_cnt--;
                    s = pool_stk[pool_cnt];
                    held_cnt++;
                    got = 1'b1;
                end
                if (got)
                begin
                    if (used_cnt < 64)
                    begin
                        used_ring[(q_first + used_cnt) % 64] = s;
                        used_cnt++;
                    end
                    w.slot = s;
                end
            end
            bqm_pkg::REQ_FREE:
            begin
                if (used_cnt == 0)
                    w.st = bqm_pkg::ST_QUEUE_EMPTY;
                else
                begin
                    forever
                    begin
                        s = used_ring[q_first];
                        if (s == lim)
                            break;
                        if (used_cnt == 1)
                        begin
                            w.st = bqm_pkg::ST_NOT_FOUND;
                            break;
                        end
                        if (cache_cnt < cap)
                        begin
                            cache_stk[cache_cnt] = s;
                            cache_cnt++;
                        end
                        else
                        begin
                            pool_push(s);
                            if (held_cnt > 0)
                                held_cnt--;
                        end
                        q_first = (q_first + 1) % 64;
                        used_cnt--;
                        w.rel++;
                    end
                end
            end
            bqm_pkg::REQ_DEL:
            begin
                while (cache_cnt > 0)
                begin
                    cache_cnt--;
                    pool_push(cache_stk[cache_cnt]);
                end
                w.rel = 7'(used_cnt);
                while (used_cnt > 0)
                begin
                    pool_push(used_ring[q_first]);
                    q_first = (q_first + 1) % 64;
                    used_cnt--;
                end
                held_cnt = 0;
            end
            default:
            begin
            end
        endcase
        w.held = 7'(held_cnt);
        return w;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= bqm_pkg::REQ_GET;
            limit_slot <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_words.push_back(apply_request(bqm_pkg::req_t'(req_type), limit_slot));
            if (!start || !busy)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    r = pending_reqs.pop_front();
                    start <= 1'b1;
                    req_type <= r.req;
                    limit_slot <= pick_limit(r.lim_mode);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word st=%0d slot=%0d held=%0d rel=%0d", $time,
                         status, buf_slot, buffers_held, released_count);
                errors++;
            end
            else
            begin
                w = expected_words.pop_front();
                checked++;
                if (status < 5)
                    status_seen[status]++;
                if (status !== w.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, w.st, status);
                    errors++;
                end
                if (buf_slot !== w.slot)
                begin
                    $display("%0t: buf_slot exp %0d got %0d", $time, w.slot, buf_slot);
                    errors++;
                end
                if (buffers_held !== w.held)
                begin
                    $display("%0t: buffers_held exp %0d got %0d", $time, w.held,
                             buffers_held);
                    errors++;
                end
                if (released_count !== w.rel)
                begin
                    $display("%0t: released_count exp %0d got %0d", $time, w.rel,
                             released_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic reg_write(logic a, int v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= a;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == ADDR_CACHE_CAP)
            cache_cap = v & 7'h7f;
        else
            mem_limit = v & 7'h7f;
    endtask

    task automatic add_req(bqm_pkg::req_t q, int mode);
        request_t r;
        r.req = q;
        r.lim_mode = mode;
        pending_reqs.push_back(r);
    endtask

    task automatic drain;
        while (pending_reqs.size() > 0 || expected_words.size() > 0 || start || busy)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_phase(int n, int cap, int lim, int pct);
        int k;
        reg_write(ADDR_CACHE_CAP, cap);
        reg_write(ADDR_MEM_LIMIT, lim);
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 55)
                add_req(bqm_pkg::REQ_GET, MODE_ANY);
            else if (k < 85)
                add_req(bqm_pkg::REQ_FREE, ($urandom_range(9) < 8) ? MODE_IN :
                        (($urandom_range(1) == 1) ? MODE_OUT : MODE_ANY));
            else if (k < 95)
                add_req(bqm_pkg::REQ_DEL, MODE_ANY);
            else
                add_req(bqm_pkg::REQ_NOP, MODE_ANY);
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        checked = 0;
        cycles = 0;
        idle_pct = 0;
        status_seen = '{default: 0};
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cache_cap = 4;
        mem_limit = 64;
        q_first = 0;
        used_cnt = 0;
        cache_cnt = 0;
        pool_cnt = 64;
        held_cnt = 0;
        for (int i = 0; i < 64; i++)
            pool_stk[i] = 6'(63 - i);
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, cache reuse, limit missing, nop, delete, budget, pool empty
        add_req(bqm_pkg::REQ_FREE, MODE_ANY);
        repeat (6) add_req(bqm_pkg::REQ_GET, MODE_ANY);
        add_req(bqm_pkg::REQ_FREE, MODE_IN);
        add_req(bqm_pkg::REQ_GET, MODE_ANY);
        add_req(bqm_pkg::REQ_FREE, MODE_OUT);
        add_req(bqm_pkg::REQ_NOP, MODE_ANY);
        add_req(bqm_pkg::REQ_GET, MODE_ANY);
        add_req(bqm_pkg::REQ_DEL, MODE_ANY);
        add_req(bqm_pkg::REQ_DEL, MODE_ANY);
        drain();
        reg_write(ADDR_MEM_LIMIT, 0);
        reg_write(ADDR_CACHE_CAP, 0);
        add_req(bqm_pkg::REQ_GET, MODE_ANY);
        add_req(bqm_pkg::REQ_FREE, MODE_ANY);
        drain();
        reg_write(ADDR_MEM_LIMIT, 127);
        repeat (66) add_req(bqm_pkg::REQ_GET, MODE_ANY);
        add_req(bqm_pkg::REQ_FREE, MODE_OUT);
        add_req(bqm_pkg::REQ_DEL, MODE_ANY);
        drain();

        random_phase(92, 0, 127, 23);
        random_phase(92, 64, 10, 45);
        random_phase(92, 100, 127, 0);
        random_phase(92, 127, 64, 0);

        $display("%0d words checked; status ok/limit/pool/empty/notfound = %0d/%0d/%0d/%0d/%0d",
                 checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
